/* rtl/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, constants and helper functions for the UTF-8 / escape decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BSLASH,
        MODE_HEX,
        MODE_NEED2,
        MODE_NEED1
    } mode_t;

    localparam logic [7:0]  BYTE_LF     = 8'h0A;
    localparam logic [7:0]  BYTE_BSLASH = 8'h5C;
    localparam logic [7:0]  BYTE_U      = 8'h75;
    localparam logic [7:0]  BYTE_LEAD3  = 8'hE0;
    localparam logic [7:0]  BYTE_LEAD2  = 8'hC0;
    localparam logic [15:0] CODE_CR     = 16'h000D;
    localparam logic [15:0] CODE_LF     = 16'h000A;
    localparam logic [15:0] CODE_BSLASH = 16'h005C;
    localparam logic [2:0]  HEX_DIGITS  = 3'd4;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [15:0] char_code;
        logic        end_marker;
        logic [31:0] line_number;
        logic [31:0] column_number;
        logic        last_of_run;
    } res_t;

    // results produced by one item, handed to the queue
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    typedef struct packed {
        logic [15:0] code;
        logic [31:0] line;
        logic [31:0] col;
        logic        drop;
    } emit_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] code;
        mode_t       mode;
        logic [15:0] acc;
    } idle_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    // one emitted character: column step, newline handling, CR -> LF
    function automatic emit_t emit_char(input logic [15:0] c, input logic [31:0] line,
                                        input logic [31:0] col, input logic drop);
        emit_t e;
        e.code = c;
        e.line = line;
        e.col  = col + 32'd1;
        e.drop = drop;
        if (c == CODE_CR || c == CODE_LF)
        begin
            e.line = line + 32'd1;
            e.col  = 32'd1;
            if (c == CODE_CR)
            begin
                e.drop = 1'b1;
                e.code = CODE_LF;
            end
        end
        return e;
    endfunction

    // byte seen with no sequence open; any pending LF drop is consumed here
    function automatic idle_t idle_byte(input logic [7:0] b, input logic drop,
                                        input logic [15:0] acc);
        idle_t r;
        r.emit = 1'b0;
        r.code = {8'h00, b};
        r.mode = MODE_IDLE;
        r.acc  = acc;
        if (drop && b == BYTE_LF)
        begin
            r.emit = 1'b0;
        end
        else if (b == BYTE_BSLASH)
        begin
            r.mode = MODE_BSLASH;
        end
        else if (b >= BYTE_LEAD3)
        begin
            r.acc  = {b[3:0], 12'h000};
            r.mode = MODE_NEED2;
        end
        else if (b >= BYTE_LEAD2)
        begin
            r.acc  = {5'b00000, b[4:0], 6'b000000};
            r.mode = MODE_NEED1;
        end
        else
        begin
            r.emit = 1'b1;
        end
        return r;
    endfunction

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'h0;
        if (b >= 8'h30 && b <= 8'h39)
            h.value = b[3:0];
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            h.value = b[3:0] + 4'd9;
        else
            h.valid = 1'b0;
        return h;
    endfunction

endpackage

/* rtl/utf8d_in_if.sv */
// ----------------------------------------------------------------------------
// utf8d_in_if
// Byte channel into the decoder: valid/ready with byte and end flag.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_stream;

    modport source (output valid, output byte_value, output end_of_stream, input ready);
    modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

/* rtl/utf8d_out_if.sv */
// ----------------------------------------------------------------------------
// utf8d_out_if
// Character channel out of the decoder: valid/ready with code and position.
// ----------------------------------------------------------------------------
interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        end_marker;
    logic [31:0] line_number;
    logic [31:0] column_number;
    logic        last_of_run;

    modport source (output valid, output char_code, output end_marker, output line_number,
                    output column_number, output last_of_run, input ready);
    modport sink   (input valid, input char_code, input end_marker, input line_number,
                    input column_number, input last_of_run, output ready);
endinterface

/* rtl/utf8d_core.sv */
// ----------------------------------------------------------------------------
// utf8d_core
// Input register, decode state and counters; produces 0..2 results per item.
// ----------------------------------------------------------------------------
module utf8d_core
(
    input  logic             clk,
    input  logic             rst_n,
    utf8d_in_if.sink         in_ch,
    input  logic             space_ok,
    output utf8d_pkg::push_t push
);
    import utf8d_pkg::*;

    logic        stage_valid_reg, stage_valid_next;
    logic [7:0]  stage_byte_reg;
    logic        stage_eos_reg;

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        drop_reg, drop_next;
    logic [31:0] line_reg, line_next;
    logic [31:0] col_reg, col_next;

    logic        accept, advance;
    idle_t       ib;
    hex_t        hx;
    logic [15:0] acc_shift;
    logic [2:0]  cnt_inc;
    logic [15:0] first_code;
    logic        first_drop;
    logic        use_first, use_second, end_res;
    logic        drop_nofirst;
    emit_t       first, second;
    res_t        res_first, res_second, res_end;

    assign in_ch.ready = !stage_valid_reg || space_ok;
    assign accept      = in_ch.valid && in_ch.ready;
    assign advance     = stage_valid_reg && space_ok;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    // decode decision for the staged item
    always_comb
    begin
        ib           = idle_byte(stage_byte_reg, drop_reg, acc_reg);
        hx           = hex_digit(stage_byte_reg);
        acc_shift    = {acc_reg[11:0], hx.value};
        cnt_inc      = cnt_reg + 3'd1;
        first_code   = CODE_BSLASH;
        first_drop   = drop_reg;
        use_first    = 1'b0;
        use_second   = 1'b0;
        end_res      = 1'b0;
        drop_nofirst = drop_reg;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        if (stage_eos_reg)
        begin
            // a lone backslash is flushed before the end result
            use_first = (mode_reg == MODE_BSLASH);
            end_res   = 1'b1;
            mode_next = MODE_IDLE;
            acc_next  = 16'h0000;
            cnt_next  = 3'd0;
        end
        else
        begin
            case (mode_reg)
                MODE_BSLASH:
                begin
                    if (stage_byte_reg == BYTE_U)
                    begin
                        mode_next = MODE_HEX;
                        acc_next  = 16'h0000;
                        cnt_next  = 3'd0;
                    end
                    else
                    begin
                        use_first    = 1'b1;
                        use_second   = ib.emit;
                        first_drop   = 1'b0;
                        drop_nofirst = 1'b0;
                        mode_next    = ib.mode;
                        acc_next     = ib.acc;
                    end
                end
                MODE_HEX:
                begin
                    if (hx.valid)
                    begin
                        acc_next = acc_shift;
                        cnt_next = cnt_inc;
                    end
                    if (!hx.valid || cnt_inc >= HEX_DIGITS)
                    begin
                        mode_next  = MODE_IDLE;
                        cnt_next   = 3'd0;
                        acc_next   = 16'h0000;
                        use_first  = 1'b1;
                        first_code = hx.valid ? acc_shift : acc_reg;
                    end
                end
                MODE_NEED2:
                begin
                    acc_next  = acc_reg | {4'h0, stage_byte_reg[5:0], 6'b000000};
                    mode_next = MODE_NEED1;
                end
                MODE_NEED1:
                begin
                    mode_next  = MODE_IDLE;
                    use_first  = 1'b1;
                    first_code = acc_reg | {10'h000, stage_byte_reg[5:0]};
                    acc_next   = 16'h0000;
                end
                default:
                begin
                    mode_next    = ib.mode;
                    acc_next     = ib.acc;
                    use_first    = ib.emit;
                    first_code   = ib.code;
                    first_drop   = 1'b0;
                    drop_nofirst = 1'b0;
                end
            endcase
        end
    end

    // counters and result words
    always_comb
    begin
        first  = emit_char(first_code, line_reg, col_reg, first_drop);
        second = emit_char(ib.code, first.line, first.col, first.drop);

        line_next = line_reg;
        col_next  = col_reg;
        drop_next = drop_nofirst;
        if (use_second)
        begin
            line_next = second.line;
            col_next  = second.col;
            drop_next = second.drop;
        end
        else if (use_first)
        begin
            line_next = first.line;
            col_next  = first.col;
            drop_next = first.drop;
        end
        if (end_res)
            drop_next = 1'b0;

        res_first  = '{char_code: first.code, end_marker: 1'b0, line_number: first.line,
                       column_number: first.col, last_of_run: !(use_second || end_res)};
        res_second = '{char_code: second.code, end_marker: 1'b0, line_number: second.line,
                       column_number: second.col, last_of_run: 1'b1};
        res_end    = '{char_code: 16'h0000, end_marker: 1'b1, line_number: line_next,
                       column_number: col_next, last_of_run: 1'b1};

        push.n  = 2'd0;
        push.r0 = res_first;
        push.r1 = end_res ? res_end : res_second;
        if (advance)
        begin
            if (use_first && (use_second || end_res))
                push.n = 2'd2;
            else if (use_first)
                push.n = 2'd1;
            else if (end_res)
            begin
                push.n  = 2'd1;
                push.r0 = res_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            mode_reg        <= MODE_IDLE;
            acc_reg         <= 16'h0000;
            cnt_reg         <= 3'd0;
            drop_reg        <= 1'b0;
            line_reg        <= 32'd1;
            col_reg         <= 32'd1;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (advance)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
                drop_reg <= drop_next;
                line_reg <= line_next;
                col_reg  <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= in_ch.byte_value;
            stage_eos_reg  <= in_ch.end_of_stream;
        end
    end

endmodule

/* rtl/utf8d_res_fifo.sv */
// ----------------------------------------------------------------------------
// utf8d_res_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module utf8d_res_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  utf8d_pkg::push_t push,
    output logic             space_ok,
    utf8d_out_if.source      out_ch
);
    import utf8d_pkg::*;

    res_t                 entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] head_reg, head_next;
    logic [RES_PTR_W-1:0] tail_reg, tail_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [RES_PTR_W-1:0] tail_plus1;
    logic                 pop;
    res_t                 head_res;

    // room for a two-result item, judged on registered state only
    assign space_ok   = count_reg <= RES_CNT_W'(RES_DEPTH - 2);
    assign pop        = out_ch.valid && out_ch.ready;
    assign tail_plus1 = tail_reg + RES_PTR_W'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + RES_PTR_W'(1) : head_reg;
        tail_next  = tail_reg + RES_PTR_W'(push.n);
        count_next = count_reg + RES_CNT_W'(push.n) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            entry_reg[tail_reg] <= push.r0;
        if (push.n == 2'd2)
            entry_reg[tail_plus1] <= push.r1;
    end

    assign head_res             = entry_reg[head_reg];
    assign out_ch.valid         = count_reg != '0;
    assign out_ch.char_code     = head_res.char_code;
    assign out_ch.end_marker    = head_res.end_marker;
    assign out_ch.line_number   = head_res.line_number;
    assign out_ch.column_number = head_res.column_number;
    assign out_ch.last_of_run   = head_res.last_of_run;

endmodule

/* rtl/utf8_escape_decoder_line_tracker.sv */
// ----------------------------------------------------------------------------
// utf8_escape_decoder_line_tracker
// UTF-8 / backslash-u decoder with CR/LF folding and line/column counters.
// ----------------------------------------------------------------------------
// Path: the first result of an item passes through the input stage register
// and then the result queue before it can be taken from out_ch.
// Throughput: one item per cycle while the queue has room; an item giving
// two results hands them out in turn. A 4-entry result queue decouples the
// sides; input stalls while an item is staged and over two results are queued.
// Reset: decode state idle, pending LF drop cleared, line and column = 1.
module utf8_escape_decoder_line_tracker
(
    input  logic        clk,
    input  logic        rst_n,
    utf8d_in_if.sink    in_ch,
    utf8d_out_if.source out_ch
);
    import utf8d_pkg::*;

    push_t push;
    logic  space_ok;

    utf8d_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .space_ok (space_ok),
        .push     (push)
    );

    utf8d_res_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .out_ch   (out_ch)
    );

    // results are only pushed when the queue has room for two
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> space_ok)
        else $error("result pushed without queue room");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> !push.r0.last_of_run && push.r1.last_of_run)
        else $error("last_of_run misplaced on two-result item");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd1 |-> push.r0.last_of_run)
        else $error("single result not marked last");

    a_end_code: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 && push.r0.end_marker |-> push.r0.char_code == 16'h0000 && push.n == 2'd1)
        else $error("end result malformed");

endmodule

/* bench/utf8_escape_decoder_line_tracker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_escape_decoder_line_tracker_tb
// Self-checking bench for the UTF-8 / backslash-u decoder. A decoder model
// inside a small class predicts the characters and line/column positions that
// each byte should produce. Every character taken from the output is checked
// field by field against the oldest prediction. A directed opening is
// followed by random, mostly well-formed byte streams. Both handshakes are
// throttled at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module utf8_escape_decoder_line_tracker_tb;
    import utf8d_pkg::*;

    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RANDOM_ITEMS = 450;
    localparam int         LONG_HOLD   = 300;

    logic clk;
    logic rst_n;

    utf8d_in_if  in_ch();
    utf8d_out_if out_ch();

    utf8_escape_decoder_line_tracker dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    typedef struct {
        logic [7:0] b;
        logic       eos;
    } byte_item_t;

    byte_item_t stream_q[$];
    int         bytes_accepted;
    int         cycles;
    bit         hold_done;

    // -1 when the byte is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    class char_predictor;
        mode_t       mode;
        logic [15:0] acc;
        logic [2:0]  digits;
        bit          drop_lf;
        logic [31:0] line;
        logic [31:0] col;
        res_t        step_chars[$];
        res_t        chars_due[$];
        int          mismatches;
        int          checked;
        int          ends_seen;
        int          double_steps;

        function new();
            mode     = MODE_IDLE;
            acc      = '0;
            digits   = '0;
            drop_lf  = 1'b0;
            line     = 32'd1;
            col      = 32'd1;
            mismatches   = 0;
            checked      = 0;
            ends_seen    = 0;
            double_steps = 0;
        endfunction

        function void put_char(input logic [15:0] c);
            res_t r;
            col = col + 32'd1;
            if (c == CODE_CR || c == CODE_LF)
            begin
                line = line + 32'd1;
                col  = 32'd1;
                if (c == CODE_CR)
                begin
                    drop_lf = 1'b1;
                    c = CODE_LF;
                end
            end
            r.char_code     = c;
            r.end_marker    = 1'b0;
            r.line_number   = line;
            r.column_number = col;
            r.last_of_run   = 1'b0;
            step_chars.push_back(r);
        endfunction

        function void plain_byte(input logic [7:0] b);
            if (drop_lf)
            begin
                drop_lf = 1'b0;
                if (b == BYTE_LF)
                    return;
            end
            if (b == BYTE_BSLASH)
                mode = MODE_BSLASH;
            else if (b >= BYTE_LEAD3)
            begin
                acc  = {b[3:0], 12'h000};
                mode = MODE_NEED2;
            end
            else if (b >= BYTE_LEAD2)
            begin
                acc  = {5'b00000, b[4:0], 6'b000000};
                mode = MODE_NEED1;
            end
            else
                put_char({8'h00, b});
        endfunction

        // called for every accepted input item
        function void take_byte(input logic [7:0] b, input logic eos);
            res_t r;
            int   v;
            bit   close_escape;
            step_chars.delete();
            if (eos)
            begin
                if (mode == MODE_BSLASH)
                    put_char(CODE_BSLASH);
                mode    = MODE_IDLE;
                acc     = '0;
                digits  = '0;
                drop_lf = 1'b0;
                r.char_code     = 16'h0000;
                r.end_marker    = 1'b1;
                r.line_number   = line;
                r.column_number = col;
                r.last_of_run   = 1'b0;
                step_chars.push_back(r);
                ends_seen++;
            end
            else
            begin
                case (mode)
                    MODE_BSLASH:
                    begin
                        mode = MODE_IDLE;
                        if (b == BYTE_U)
                        begin
                            mode   = MODE_HEX;
                            acc    = '0;
                            digits = '0;
                        end
                        else
                        begin
                            put_char(CODE_BSLASH);
                            plain_byte(b);
                        end
                    end
                    MODE_HEX:
                    begin
                        v = hex_nibble(b);
                        close_escape = 1'b1;
                        if (v >= 0)
                        begin
                            acc    = {acc[11:0], v[3:0]};
                            digits = digits + 3'd1;
                            if (digits < HEX_DIGITS)
                                close_escape = 1'b0;
                        end
                        if (close_escape)
                        begin
                            mode   = MODE_IDLE;
                            digits = '0;
                            put_char(acc);
                            acc = '0;
                        end
                    end
                    MODE_NEED2:
                    begin
                        acc  = acc | {4'h0, b[5:0], 6'b000000};
                        mode = MODE_NEED1;
                    end
                    MODE_NEED1:
                    begin
                        mode = MODE_IDLE;
                        put_char(acc | {10'b0, b[5:0]});
                        acc = '0;
                    end
                    default:
                    begin
                        mode = MODE_IDLE;
                        plain_byte(b);
                    end
                endcase
            end
            if (step_chars.size() > 1)
                double_steps++;
            foreach (step_chars[i])
            begin
                r = step_chars[i];
                r.last_of_run = (i == step_chars.size() - 1);
                chars_due.push_back(r);
            end
        endfunction

        function void check_char(input res_t got);
            res_t want;
            if (chars_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected char: code %h end %b line %0d col %0d last %b",
                             $realtime, got.char_code, got.end_marker, got.line_number,
                             got.column_number, got.last_of_run);
                return;
            end
            want = chars_due.pop_front();
            checked++;
            if (got.char_code !== want.char_code || got.end_marker !== want.end_marker ||
                got.line_number !== want.line_number ||
                got.column_number !== want.column_number ||
                got.last_of_run !== want.last_of_run)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] char mismatch: want code %h end %b line %0d col %0d last %b",
                             $realtime, want.char_code, want.end_marker, want.line_number,
                             want.column_number, want.last_of_run);
                    $display("                      got code %h end %b line %0d col %0d last %b",
                             got.char_code, got.end_marker, got.line_number,
                             got.column_number, got.last_of_run);
                end
            end
        endfunction
    endclass

    char_predictor decoder_model;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- stream building ----------------

    task automatic push_byte(input logic [7:0] b);
        byte_item_t it;
        it.b   = b;
        it.eos = 1'b0;
        stream_q.push_back(it);
    endtask

    task automatic push_end();
        byte_item_t it;
        it.b   = 8'($urandom);
        it.eos = 1'b1;
        stream_q.push_back(it);
    endtask

    function automatic logic [7:0] rand_hex_char();
        case ($urandom_range(0, 2))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return 8'("a" + $urandom_range(0, 5));
            default: return 8'("A" + $urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] rand_cont();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    task automatic build_directed();
        push_byte(8'h41);
        push_byte(8'h00);
        push_byte(BYTE_CR);
        push_byte(BYTE_LF);              // swallowed after CR
        // \u000D: escape giving CR, then the raw LF after it is swallowed
        push_byte(BYTE_BSLASH);
        push_byte(BYTE_U);
        push_byte("0");
        push_byte("0");
        push_byte("0");
        push_byte("D");
        push_byte(BYTE_LF);
        // empty escape, terminator eaten
        push_byte(BYTE_BSLASH);
        push_byte(BYTE_U);
        push_byte("g");
        // backslash not followed by u: two chars from one item
        push_byte(BYTE_BSLASH);
        push_byte("x");
        push_byte(8'hC3);
        push_byte(8'hA9);
        push_byte(8'hFF);
        push_byte(8'hBF);
        push_byte(8'hBF);
        // end inside a 3-byte sequence, then after a lone backslash
        push_byte(8'hE2);
        push_end();
        push_byte(BYTE_BSLASH);
        push_end();
        push_byte(8'h7F);
    endtask

    task automatic build_random(input int n);
        int start;
        int k;
        start = stream_q.size();
        while (stream_q.size() - start < n)
        begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3:
                    push_byte(8'($urandom_range(8'h20, 8'h7E)));
                4:
                    push_byte(8'($urandom_range(0, 255)));
                5:
                    push_byte(BYTE_CR);
                6:
                    push_byte(BYTE_LF);
                7:
                begin
                    push_byte(BYTE_CR);
                    push_byte(BYTE_LF);
                end
                8, 9:
                begin
                    push_byte(8'($urandom_range(8'hC0, 8'hDF)));
                    push_byte(rand_cont());
                end
                10, 11:
                begin
                    push_byte(8'($urandom_range(8'hE0, 8'hFF)));
                    push_byte(rand_cont());
                    push_byte(rand_cont());
                end
                12, 13:
                begin
                    push_byte(BYTE_BSLASH);
                    push_byte(BYTE_U);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        // escape that yields a newline
                        push_byte("0");
                        push_byte("0");
                        push_byte("0");
                        case ($urandom_range(0, 3))
                            0:       push_byte("D");
                            1:       push_byte("d");
                            2:       push_byte("A");
                            default: push_byte("a");
                        endcase
                        if ($urandom_range(0, 1) == 1)
                            push_byte(BYTE_LF);
                    end
                    else
                    begin
                        k = $urandom_range(0, 4);
                        repeat (k)
                            push_byte(rand_hex_char());
                        if (k < 4)
                            push_byte(rand_non_hex());
                    end
                end
                14:
                begin
                    push_byte(BYTE_BSLASH);
                    do
                        k = $urandom_range(0, 255);
                    while (k == int'(BYTE_U));
                    push_byte(8'(k));
                end
                default:
                begin
                    // end marker, sometimes cutting a sequence short
                    case ($urandom_range(0, 3))
                        0:
                            push_byte(8'($urandom_range(8'hC0, 8'hFF)));
                        1:
                        begin
                            push_byte(BYTE_BSLASH);
                            push_byte(BYTE_U);
                            repeat ($urandom_range(0, 3))
                                push_byte(rand_hex_char());
                        end
                        2:
                            push_byte(BYTE_BSLASH);
                        default:
                            ;
                    endcase
                    push_end();
                end
            endcase
        end
    endtask

    // ---------------- input side ----------------

    task automatic send_item(input byte_item_t it);
        @(negedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.byte_value    <= it.b;
        in_ch.end_of_stream <= it.eos;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        decoder_model.take_byte(it.b, it.eos);
        bytes_accepted++;
    endtask

    task automatic idle_input(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_ch.valid         <= 1'b0;
            in_ch.byte_value    <= 8'($urandom);
            in_ch.end_of_stream <= 1'($urandom);
        end
    endtask

    task automatic send_stream();
        int burst;
        while (stream_q.size() > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && stream_q.size() > 0)
            begin
                send_item(stream_q.pop_front());
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 12));
        end
        idle_input(1);
    endtask

    task automatic wait_chars_drained();
        while (decoder_model.chars_due.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- output side ----------------

    initial
    begin
        logic [15:0] ready_pat;
        int          pos;
        int          hold_left;
        ready_pat = 16'hFFFF;
        pos       = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && bytes_accepted >= 200)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (pos % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pat = 16'hFFFF;
                    1:       ready_pat = 16'($urandom);
                    2:       ready_pat = 16'($urandom) | 16'($urandom);
                    default: ready_pat = 16'hA5F0 ^ 16'($urandom_range(0, 15));
                endcase
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ready_pat[pos % 16];
            pos++;
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chars still due", cycles,
                     decoder_model.chars_due.size());
            $display("utf8_escape_decoder_line_tracker verification failed");
            $finish;
        end
        else if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.char_code     = out_ch.char_code;
            got.end_marker    = out_ch.end_marker;
            got.line_number   = out_ch.line_number;
            got.column_number = out_ch.column_number;
            got.last_of_run   = out_ch.last_of_run;
            decoder_model.check_char(got);
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        int failures;
        decoder_model       = new();
        bytes_accepted      = 0;
        cycles              = 0;
        hold_done           = 1'b0;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.byte_value    = 8'h00;
        in_ch.end_of_stream = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        build_directed();
        send_stream();
        // sender holds back until everything decoded so far has come out
        wait_chars_drained();

        build_random(RANDOM_ITEMS);
        send_stream();
        wait_chars_drained();
        repeat (20)
            @(posedge clk);

        failures = decoder_model.mismatches + decoder_model.chars_due.size();
        $display("%0d bytes/end markers in, %0d chars checked, %0d end results, %0d two-char items",
                 bytes_accepted, decoder_model.checked, decoder_model.ends_seen,
                 decoder_model.double_steps);
        $display("covered 2/3-byte sequences, hex escapes, CR/LF folding, cut-off sequences, %s",
                 "random stalls on both sides and a long output hold-off");
        if (failures == 0)
            $display("utf8_escape_decoder_line_tracker verification clean");
        else
            $display("utf8_escape_decoder_line_tracker verification failed");
        $finish;
    end

endmodule
